// ===== design/bdq_pkg.sv =====
// Shared constants, codes and types for the bounded deque with positional insert.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MODE_W    = 3;
  localparam int POS_W     = 5;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int SIZE_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK    = 3'd0,
    MODE_PUSH_FRONT   = 3'd1,
    MODE_REMOVE_BACK  = 3'd2,
    MODE_REMOVE_FRONT = 3'd3,
    MODE_INSERT       = 3'd4
  } bdq_mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } bdq_status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } bdq_op_t;

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } bdq_state_t;

  // Command broadcast to one cell of the row.
  typedef struct packed {
    bdq_op_t op;
    logic    at;     // this cell is the target index
    logic    above;  // this cell lies past the target index
  } bdq_ctl_t;

endpackage

// ===== design/bdq_if.sv =====
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps

interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [SIZE_W-1:0]        size;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output status, output size, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input size, input front_value,
                  input back_value, output ready);
endinterface

// ===== design/bdq_cell.sv =====
// One storage cell of the deque row, shifting with its neighbors on insert or remove.
`timescale 1ns / 1ps

module bdq_cell import bdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bdq_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_valid,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] data,
  output logic                     valid
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctl.op)
      OP_INSERT: begin
        if (ctl.at) begin
          data_nxt  = ins_value;
          valid_nxt = 1'b1;
        end else if (ctl.above) begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
      end
      OP_REMOVE: begin
        if (ctl.at || ctl.above) begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

// ===== design/bdq_back_pick.sv =====
// Selects the value of the last occupied cell from the row's valid pattern.
`timescale 1ns / 1ps

module bdq_back_pick import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic signed [DATA_W-1:0] cell_data [DEPTH],
  input  logic                     cell_valid [DEPTH],
  output logic signed [DATA_W-1:0] back
);

  logic [DEPTH-1:0] is_last;

  // Valid cells form a run from cell 0, so exactly one cell ends it unless empty.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      is_last[i] = cell_valid[i] && !cell_valid[i+1];
    end
    is_last[DEPTH-1] = cell_valid[DEPTH-1];
  end

  always_comb begin
    back = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back = back | (cell_data[i] & {DATA_W{is_last[i]}});
    end
  end

endmodule

// ===== design/bounded_deque_positional_insert_top.sv =====
// Bounded deque with positional insert, built as a row of shifting cells.
// Requests are taken only in the idle state, and only while the result register is free.
// The row shifts at the accept; in the report state after it, the front and back values
// are picked from the updated row into the result register, which then shows valid.
// Reset: synchronous, active low; clears the element count and the cell valid bits.
`timescale 1ns / 1ps

module bounded_deque_positional_insert_top import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

  bdq_state_t state_r, state_nxt;

  logic [OCC_W-1:0] occ_r, occ_nxt;
  bdq_status_t      status_r, stat_dec;
  bdq_op_t          op_dec, op_eff;
  logic [IDX_W-1:0] idx_dec;

  logic                     accept;
  logic                     full, empty, bad_pos;
  logic                     load_out;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] front_r, back_r;
  logic [SIZE_W-1:0]        size_r;

  logic signed [DATA_W-1:0] cell_data  [DEPTH];
  logic                     cell_valid [DEPTH];
  logic signed [DATA_W-1:0] back_pick;

  assign accept  = in_ch.valid && in_ch.ready;
  assign full    = (occ_r == OCC_W'(DEPTH));
  assign empty   = (occ_r == '0);
  assign bad_pos = (in_ch.position == '0) || (CMP_W'(in_ch.position) > CMP_W'(occ_r));

  // Request decode: which shift the row performs, where, and the status.
  always_comb begin
    op_dec   = OP_HOLD;
    idx_dec  = '0;
    stat_dec = STAT_DONE;
    unique case (bdq_mode_t'(in_ch.mode))
      MODE_PUSH_BACK: begin
        if (full) begin
          stat_dec = STAT_FULL;
        end else begin
          op_dec  = OP_INSERT;
          idx_dec = IDX_W'(occ_r);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          stat_dec = STAT_FULL;
        end else begin
          op_dec = OP_INSERT;
        end
      end
      MODE_REMOVE_BACK: begin
        if (empty) begin
          stat_dec = STAT_EMPTY;
        end else begin
          op_dec  = OP_REMOVE;
          idx_dec = IDX_W'(occ_r - 1'b1);
        end
      end
      MODE_REMOVE_FRONT: begin
        if (empty) begin
          stat_dec = STAT_EMPTY;
        end else begin
          op_dec = OP_REMOVE;
        end
      end
      MODE_INSERT: begin
        if (full) begin
          stat_dec = STAT_FULL;
        end else if (bad_pos) begin
          stat_dec = STAT_BADPOS;
        end else begin
          op_dec  = OP_INSERT;
          idx_dec = IDX_W'(in_ch.position);
        end
      end
      default: begin
      end
    endcase
  end

  assign op_eff = accept ? op_dec : OP_HOLD;

  always_comb begin
    occ_nxt = occ_r;
    case (op_eff)
      OP_INSERT: occ_nxt = occ_r + 1'b1;
      OP_REMOVE: occ_nxt = occ_r - 1'b1;
      default:   occ_nxt = occ_r;
    endcase
  end

  // Cell row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_ctl_t                 ctl;
    logic signed [DATA_W-1:0] left_data, right_data;
    logic                     left_valid, right_valid;

    assign ctl.op    = op_eff;
    assign ctl.at    = (IDX_W'(i) == idx_dec);
    assign ctl.above = (IDX_W'(i) > idx_dec);

    if (i == 0) begin : g_first
      assign left_data  = '0;
      assign left_valid = 1'b0;
    end else begin : g_inner_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    bdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .ins_value   (in_ch.value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  bdq_back_pick #(
    .DEPTH (DEPTH)
  ) u_back_pick (
    .cell_data  (cell_data),
    .cell_valid (cell_valid),
    .back       (back_pick)
  );

  // Sequencer: accept, then report from the updated row.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_REPORT;
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ch.ready = !out_valid_r || out_ch.ready;
      S_REPORT: load_out = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= stat_dec;
    end
    if (load_out) begin
      size_r  <= SIZE_W'(occ_r);
      front_r <= cell_valid[0] ? cell_data[0] : '0;
      back_r  <= back_pick;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.size        = size_r;
  assign out_ch.front_value = front_r;
  assign out_ch.back_value  = back_r;

endmodule
